[src/room_fanout_table_with_aging_defines.svh]
// Assertion macros for the room fan-out table checker.
`ifndef ROOM_FANOUT_TABLE_WITH_AGING_DEFINES_SVH
`define ROOM_FANOUT_TABLE_WITH_AGING_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define RFT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rft check failed");
// Assert that a condition implies a consequence in the next cycle.
`define RFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rft check failed");
`endif

[src/rft_pkg.sv]
// Shared types and constants for the room fan-out table.
`default_nettype none
package rft_pkg;
  localparam logic [1:0] KIND_RECIP = 2'd0;
  localparam logic [1:0] KIND_NONE  = 2'd1;
  localparam logic [1:0] KIND_REAP  = 2'd2;
  localparam logic       OP_PACKET  = 1'b0;
  localparam logic       OP_REAP    = 1'b1;
  localparam int unsigned RESULT_CAP = 15;
  localparam logic [6:0] COUNT_MAX  = 7'd127;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic        not_stored;
    logic [6:0]  dropped_count;
    logic [6:0]  peer_total;
    logic        last;
  } result_t;
endpackage
`default_nettype wire

[src/room_fanout_table_with_aging.sv]
// Top level of the room fan-out table with aging.
//
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------------
//  input   | in_valid_i / in_stall_o   | op, room_id, peer_id, src_ip, src_port, now_ticks
//  output  | out_valid_o / out_stall_i | kind, dest_ip, dest_port, flags, counts, last
//  config  | cfg_we_i                  | cfg_wdata_i (ttl_ticks)
//
// The scan reads one slot per cycle through the single read port.
// A packet then passes a decide state, an emit state for its N recipients (at most 15) and a
// done state; in_stall_o stays high until the block is back in idle, so a new input waits.
// A reap ages and clears slots during the scan.
// A stall of the output register while it holds a result holds up the emit and done states.
// Reset clears the valid bits at once; entry payload memory needs no clearing.
`default_nettype none
module room_fanout_table_with_aging #(
  parameter int unsigned ENTRIES   = 64,
  parameter int unsigned MAX_PEERS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [63:0] room_id_i,
  input  wire logic [31:0] peer_id_i,
  input  wire logic [31:0] src_ip_i,
  input  wire logic [15:0] src_port_i,
  input  wire logic [31:0] now_ticks_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [31:0]      dest_ip_o,
  output logic [15:0]      dest_port_o,
  output logic             not_stored_o,
  output logic [6:0]       dropped_count_o,
  output logic [6:0]       peer_total_o,
  output logic             last_o
);
  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned QW = 4;

  // Entry memory: room, peer, ip, port, seen.
  typedef struct packed {
    logic [63:0] room;
    logic [31:0] peer;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] seen;
  } entry_t;

  entry_t mem [ENTRIES];
  entry_t rd_q;
  logic [ENTRIES-1:0] valid_q;

  rft_pkg::state_e state_q, state_d;
  logic [31:0] ttl_q;
  logic        op_q;
  logic [63:0] room_q;
  logic [31:0] peer_q, ip_q, now_q;
  logic [15:0] port_q;

  logic [AW:0] idx_q;         // read address issued
  logic [AW-1:0] rd_idx_q;    // address of rd_q
  logic        rd_vld_q;      // rd_q holds a slot
  logic        match_q, free_q;
  logic [AW-1:0] match_idx_q, free_idx_q;
  logic [CW-1:0] in_room_q, total_q, dropped_q;
  logic        ns_q;
  logic [CW-1:0] total_after_q;

  // Recipient queue captured during the scan.
  logic [31:0] q_ip   [rft_pkg::RESULT_CAP];
  logic [15:0] q_port [rft_pkg::RESULT_CAP];
  logic [QW-1:0] q_cnt_q, q_rd_q;

  rft_pkg::result_t res_q;
  logic out_valid_q;

  logic acc_in, acc_out;
  assign acc_in  = in_valid_i && !in_stall_o;
  assign acc_out = out_valid_q && !out_stall_i;

  // Memory write port and read address.
  logic          we;
  logic [AW-1:0] wa;
  entry_t        wd;
  logic [AW-1:0] ra;
  assign ra = idx_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  function automatic logic [6:0] sat(input logic [CW-1:0] n);
    if ({{(32-CW){1'b0}}, n} > 32'd127) return rft_pkg::COUNT_MAX;
    return 7'(n);
  endfunction

  // Scan stage helpers.
  logic cur_valid, cur_room, cur_peer, cur_stale, scan_end;
  logic [31:0] age;
  assign cur_valid = rd_vld_q && valid_q[rd_idx_q];
  assign cur_room  = rd_q.room == room_q;
  assign cur_peer  = rd_q.peer == peer_q;
  assign age       = now_q - rd_q.seen;
  assign cur_stale = age > ttl_q;
  assign scan_end  = rd_vld_q && rd_idx_q == AW'(ENTRIES - 1)
                     && idx_q == (AW+1)'(ENTRIES);

  // Decision for a packet.
  logic          store_new;
  logic          ns_calc;
  logic [AW-1:0] slot_sel;
  always_comb begin
    store_new = 1'b0;
    ns_calc   = 1'b0;
    slot_sel  = match_idx_q;
    if (!match_q) begin
      if (!free_q || {{(32-CW){1'b0}}, in_room_q} >= MAX_PEERS) ns_calc = 1'b1;
      else begin
        store_new = 1'b1;
        slot_sel  = free_idx_q;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rft_pkg::ST_IDLE:   if (acc_in) state_d = rft_pkg::ST_SCAN;
      rft_pkg::ST_SCAN:   if (scan_end)
                            state_d = (op_q == rft_pkg::OP_REAP) ? rft_pkg::ST_DONE
                                                                 : rft_pkg::ST_DECIDE;
      rft_pkg::ST_DECIDE: state_d = rft_pkg::ST_EMIT;
      rft_pkg::ST_EMIT:   if (!out_valid_q || acc_out) begin
                            if (q_rd_q >= q_cnt_q && (q_cnt_q != '0 || q_rd_q != '0))
                              state_d = rft_pkg::ST_DONE;
                            else if (q_cnt_q == '0) state_d = rft_pkg::ST_DONE;
                          end
      rft_pkg::ST_DONE:   if (!out_valid_q || acc_out) state_d = rft_pkg::ST_IDLE;
      default:            state_d = rft_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = rd_idx_q;
    wd = rd_q;
    if (state_q == rft_pkg::ST_DECIDE && (match_q || store_new)) begin
      we = 1'b1;
      wa = slot_sel;
      wd.room = room_q;
      wd.peer = peer_q;
      wd.ip   = ip_q;
      wd.port = port_q;
      wd.seen = now_q;
    end
  end

  assign in_stall_o = state_q != rft_pkg::ST_IDLE;

  // Advance the output register when it is free or being emptied this cycle.
  logic emit_go, reap_load, out_load;
  assign emit_go   = state_q == rft_pkg::ST_EMIT && (!out_valid_q || acc_out);
  assign reap_load = state_q == rft_pkg::ST_DONE && op_q == rft_pkg::OP_REAP
                     && (!out_valid_q || acc_out);
  assign out_load  = (emit_go && (q_rd_q < q_cnt_q || q_cnt_q == '0)) || reap_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rft_pkg::ST_IDLE;
      ttl_q       <= 32'd30;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      q_cnt_q     <= '0;
      q_rd_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && !acc_out);
      if (cfg_we_i) ttl_q <= cfg_wdata_i;
      case (state_q)
        rft_pkg::ST_IDLE: begin
          if (acc_in) begin
            idx_q    <= '0;
            rd_vld_q <= 1'b0;
            q_cnt_q  <= '0;
            q_rd_q   <= '0;
          end
        end
        rft_pkg::ST_SCAN: begin
          if (idx_q < (AW+1)'(ENTRIES)) idx_q <= idx_q + 1'b1;
          rd_vld_q <= idx_q < (AW+1)'(ENTRIES);
          if (cur_valid && op_q == rft_pkg::OP_REAP && cur_stale)
            valid_q[rd_idx_q] <= 1'b0;
          if (cur_valid && op_q == rft_pkg::OP_PACKET && cur_room && !cur_peer
              && q_cnt_q < QW'(rft_pkg::RESULT_CAP)) begin
            q_cnt_q <= q_cnt_q + 1'b1;
          end
        end
        rft_pkg::ST_DECIDE: begin
          if (store_new) valid_q[free_idx_q] <= 1'b1;
        end
        rft_pkg::ST_EMIT: begin
          if (emit_go && q_rd_q < q_cnt_q) q_rd_q <= q_rd_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Payload and scan accumulators.
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      op_q      <= op_i;
      room_q    <= room_id_i;
      peer_q    <= peer_id_i;
      ip_q      <= src_ip_i;
      port_q    <= src_port_i;
      now_q     <= now_ticks_i;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      in_room_q <= '0;
      total_q   <= '0;
      dropped_q <= '0;
    end
    rd_idx_q <= ra;
    if (state_q == rft_pkg::ST_SCAN && rd_vld_q) begin
      if (cur_valid) begin
        if (op_q == rft_pkg::OP_REAP) begin
          if (cur_stale) dropped_q <= dropped_q + 1'b1;
          else total_q <= total_q + 1'b1;
        end else begin
          total_q <= total_q + 1'b1;
          if (cur_room) begin
            in_room_q <= in_room_q + 1'b1;
            if (cur_peer) begin
              match_q     <= 1'b1;
              match_idx_q <= rd_idx_q;
            end else if (q_cnt_q < QW'(rft_pkg::RESULT_CAP)) begin
              q_ip[q_cnt_q]   <= rd_q.ip;
              q_port[q_cnt_q] <= rd_q.port;
            end
          end
        end
      end else if (!free_q) begin
        free_q      <= 1'b1;
        free_idx_q  <= rd_idx_q;
      end
    end
    if (state_q == rft_pkg::ST_DECIDE) begin
      ns_q          <= ns_calc;
      total_after_q <= total_q + CW'(store_new);
    end
    if (state_q == rft_pkg::ST_EMIT && emit_go) begin
      res_q.dropped_count <= '0;
      res_q.not_stored    <= ns_q;
      res_q.peer_total    <= sat(total_after_q);
      if (q_cnt_q == '0) begin
        res_q.kind      <= rft_pkg::KIND_NONE;
        res_q.dest_ip   <= '0;
        res_q.dest_port <= '0;
        res_q.last      <= 1'b1;
      end else if (q_rd_q < q_cnt_q) begin
        res_q.kind      <= rft_pkg::KIND_RECIP;
        res_q.dest_ip   <= q_ip[q_rd_q];
        res_q.dest_port <= q_port[q_rd_q];
        res_q.last      <= (q_rd_q + 1'b1) == q_cnt_q;
      end
    end
    if (reap_load) begin
      res_q.kind          <= rft_pkg::KIND_REAP;
      res_q.dest_ip       <= '0;
      res_q.dest_port     <= '0;
      res_q.not_stored    <= 1'b0;
      res_q.dropped_count <= sat(dropped_q);
      res_q.peer_total    <= sat(total_q);
      res_q.last          <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = res_q.kind;
  assign dest_ip_o       = res_q.dest_ip;
  assign dest_port_o     = res_q.dest_port;
  assign not_stored_o    = res_q.not_stored;
  assign dropped_count_o = res_q.dropped_count;
  assign peer_total_o    = res_q.peer_total;
  assign last_o          = res_q.last;
endmodule
`default_nettype wire

[src/rft_checker.sv]
// Port-level checker for the room fan-out table, bound to the top level.
`default_nettype none
`include "room_fanout_table_with_aging_defines.svh"
module rft_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] kind_o,
  input wire logic [6:0] dropped_count_o,
  input wire logic       not_stored_o,
  input wire logic       last_o
);
  `RFT_ASSERT_IMPL(a_reap_last, clk_i, rst_ni, out_valid_o && kind_o == rft_pkg::KIND_REAP, last_o && !not_stored_o)
  `RFT_ASSERT_IMPL(a_none_last, clk_i, rst_ni, out_valid_o && kind_o == rft_pkg::KIND_NONE, last_o)
  `RFT_ASSERT_IMPL(a_pkt_nodrop, clk_i, rst_ni, out_valid_o && kind_o != rft_pkg::KIND_REAP, dropped_count_o == 7'd0)
  `RFT_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(kind_o))
  `RFT_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
endmodule

bind room_fanout_table_with_aging rft_checker u_rft_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .kind_o(kind_o),
  .dropped_count_o(dropped_count_o), .not_stored_o(not_stored_o), .last_o(last_o)
);
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the room fan-out table with aging.
`timescale 1ns / 100ps
module tb;
  localparam int unsigned ENTRIES   = 64;
  localparam int unsigned MAX_PEERS = 16;
  localparam int unsigned LIMIT     = 800000;
  localparam int unsigned DRAIN     = 80;  // a full table scan plus margin

  typedef struct {
    logic             op;
    logic [63:0]      room;
    logic [31:0]      peer;
    logic [31:0]      ip;
    logic [15:0]      port;
    logic [31:0]      now;
    bit               typed;    // expected result typed in below
    rft_pkg::result_t res;
  } item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = 1'b0;
  logic [63:0] room_id_i = '0;
  logic [31:0] peer_id_i = '0;
  logic [31:0] src_ip_i = '0;
  logic [15:0] src_port_i = '0;
  logic [31:0] now_ticks_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [1:0]  kind_o;
  logic [31:0] dest_ip_o;
  logic [15:0] dest_port_o;
  logic        not_stored_o;
  logic [6:0]  dropped_count_o;
  logic [6:0]  peer_total_o;
  logic        last_o;

  room_fanout_table_with_aging #(.ENTRIES(ENTRIES), .MAX_PEERS(MAX_PEERS)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .op_i, .room_id_i, .peer_id_i, .src_ip_i, .src_port_i, .now_ticks_i,
    .out_valid_o, .out_stall_i, .kind_o, .dest_ip_o, .dest_port_o,
    .not_stored_o, .dropped_count_o, .peer_total_o, .last_o
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the table and the TTL register.
  logic [31:0] ttl_shadow;
  bit          slot_used [ENTRIES];
  logic [63:0] slot_room [ENTRIES];
  logic [31:0] slot_peer [ENTRIES];
  logic [31:0] slot_ip   [ENTRIES];
  logic [15:0] slot_port [ENTRIES];
  logic [31:0] slot_seen [ENTRIES];

  rft_pkg::result_t fanout_q[$];   // results still owed by the block
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned items_sent = 0, results_seen = 0, refused_seen = 0, capped_seen = 0;
  bit          quiet_rx = 1'b0;  // receiver never stalls while set
  bit          hold_req = 1'b0;  // ask the receiver for one long hold-off
  bit          quiet_tx = 1'b0;

  function automatic logic [6:0] sat7(int unsigned n);
    return (n > 127) ? rft_pkg::COUNT_MAX : 7'(n);
  endfunction

  // Append one expected result to the tail of the queue.
  function automatic void queue_result(rft_pkg::result_t r);
    fanout_q = {fanout_q, r};
  endfunction

  // Apply one transaction to the shadow table and queue the results it causes.
  function automatic void predict_fanout(item_t it);
    int               match, free_slot, n;
    int unsigned      in_room, total, dropped;
    bit               refused;
    rft_pkg::result_t r;
    match = -1; free_slot = -1; n = 0; in_room = 0; total = 0; dropped = 0;
    refused = 1'b0;
    r = '0;
    if (it.op == rft_pkg::OP_REAP) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_used[i] && (it.now - slot_seen[i]) > ttl_shadow) begin
          slot_used[i] = 1'b0;
          dropped++;
        end
        if (slot_used[i]) total++;
      end
      r.kind = rft_pkg::KIND_REAP; r.dropped_count = sat7(dropped);
      r.peer_total = sat7(total); r.last = 1'b1;
      queue_result(r);
      return;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i]) begin
        if (slot_room[i] == it.room) begin
          in_room++;
          if (slot_peer[i] == it.peer) match = i;
        end
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (match < 0) begin
      if (free_slot < 0 || in_room >= MAX_PEERS) begin
        refused = 1'b1;
      end else begin
        match = free_slot;
        slot_used[match] = 1'b1;
        slot_room[match] = it.room;
        slot_peer[match] = it.peer;
      end
    end
    if (match >= 0) begin
      slot_ip[match] = it.ip; slot_port[match] = it.port; slot_seen[match] = it.now;
    end
    foreach (slot_used[i]) if (slot_used[i]) total++;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_room[i] == it.room && slot_peer[i] != it.peer) begin
        if (n == rft_pkg::RESULT_CAP) begin
          capped_seen++;
          break;
        end
        r = '0;
        r.kind = rft_pkg::KIND_RECIP; r.dest_ip = slot_ip[i]; r.dest_port = slot_port[i];
        r.not_stored = refused; r.peer_total = sat7(total);
        queue_result(r);
        n++;
      end
    end
    if (refused) refused_seen++;
    if (n == 0) begin
      r = '0;
      r.kind = rft_pkg::KIND_NONE; r.not_stored = refused;
      r.peer_total = sat7(total); r.last = 1'b1;
      queue_result(r);
    end else begin
      fanout_q[$].last = 1'b1;
    end
  endfunction

  // Offer one transaction after a random gap; hold it until accepted.
  task automatic send_item(item_t it);
    int unsigned gap, depth;
    gap = quiet_tx ? 0 : $urandom_range(0, 13);
    repeat (gap) @(negedge clk_i);
    in_valid_i = 1'b1;
    op_i = it.op; room_id_i = it.room; peer_id_i = it.peer;
    src_ip_i = it.ip; src_port_i = it.port; now_ticks_i = it.now;
    do @(posedge clk_i); while (in_stall_o);
    depth = fanout_q.size();
    predict_fanout(it);
    // Swap in the hand-written expectation where the row carries one.
    if (it.typed) begin
      while (fanout_q.size() > depth) void'(fanout_q.pop_back());
      queue_result(it.res);
    end
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Wait for the block to go idle, then write the TTL register.
  task automatic set_ttl(logic [31:0] value);
    wait (fanout_q.size() == 0);
    repeat (DRAIN) @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    ttl_shadow = value;
  endtask

  // Receiver: draw a stall length per result, with one long hold-off on request.
  initial begin : rx_stall
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (500) @(negedge clk_i);
        hold_req = 1'b0;
      end
      n = quiet_rx ? 0 : $urandom_range(0, 13);
      out_stall_i = (n != 0);
      repeat (n) @(negedge clk_i);
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    rft_pkg::result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (fanout_q.size() == 0) begin
        $error("result with nothing expected: kind %0d", kind_o);
        fail_cnt++;
      end else begin
        e = fanout_q.pop_front();
        if (kind_o !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, kind_o); fail_cnt++;
        end
        if (dest_ip_o !== e.dest_ip) begin
          $error("dest_ip: expected %h, got %h", e.dest_ip, dest_ip_o); fail_cnt++;
        end
        if (dest_port_o !== e.dest_port) begin
          $error("dest_port: expected %h, got %h", e.dest_port, dest_port_o); fail_cnt++;
        end
        if (not_stored_o !== e.not_stored) begin
          $error("not_stored: expected %0d, got %0d", e.not_stored, not_stored_o);
          fail_cnt++;
        end
        if (dropped_count_o !== e.dropped_count) begin
          $error("dropped_count: expected %0d, got %0d", e.dropped_count, dropped_count_o);
          fail_cnt++;
        end
        if (peer_total_o !== e.peer_total) begin
          $error("peer_total: expected %0d, got %0d", e.peer_total, peer_total_o);
          fail_cnt++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, last_o); fail_cnt++;
        end
      end
    end
  end

  // Watchdog: abort a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Directed rows; typed expectations only where obvious.
  function automatic item_t row(logic op, logic [63:0] room, logic [31:0] peer,
                                logic [31:0] ip, logic [15:0] port, logic [31:0] now,
                                bit typed, logic [1:0] kind, logic ns,
                                logic [6:0] dropped, logic [6:0] total);
    item_t it;
    it.op = op; it.room = room; it.peer = peer; it.ip = ip; it.port = port; it.now = now;
    it.typed = typed;
    it.res = '0;
    it.res.kind = kind; it.res.not_stored = ns; it.res.dropped_count = dropped;
    it.res.peer_total = total; it.res.last = 1'b1;
    return it;
  endfunction

  initial begin : stimulus
    item_t       dir_tab[$];
    item_t       it;
    logic [63:0] rooms[5];
    logic [31:0] peers[24];
    logic [31:0] now_cnt;
    logic [31:0] ttl_set[4];
    int unsigned pick;

    ttl_shadow = 32'd30;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty table, extreme keys and payloads, overwrite, aging at the TTL edge.
    dir_tab = {dir_tab, row(rft_pkg::OP_REAP, 64'h0, 32'h0, 32'h0, 16'h0, 32'd0,
                            1, rft_pkg::KIND_REAP, 0, 7'd0, 7'd0)};
    dir_tab = {dir_tab, row(rft_pkg::OP_PACKET, 64'hA5, 32'd1, 32'hFFFF_FFFF, 16'hFFFF,
                            32'd0, 1, rft_pkg::KIND_NONE, 0, 7'd0, 7'd1)};
    dir_tab = {dir_tab, row(rft_pkg::OP_PACKET, 64'hA5, 32'd2, 32'h0, 16'h0, 32'd0,
                            0, rft_pkg::KIND_RECIP, 0, 7'd0, 7'd0)};
    dir_tab = {dir_tab, row(rft_pkg::OP_PACKET, 64'hA5, 32'd1, 32'h0A00_0001, 16'd5000,
                            32'd0, 0, rft_pkg::KIND_RECIP, 0, 7'd0, 7'd0)};
    dir_tab = {dir_tab, row(rft_pkg::OP_PACKET, 64'h0, 32'h0, 32'h5555_5555, 16'h5555,
                            32'd0, 1, rft_pkg::KIND_NONE, 0, 7'd0, 7'd3)};
    dir_tab = {dir_tab, row(rft_pkg::OP_PACKET, '1, '1, 32'hAAAA_AAAA, 16'hAAAA,
                            32'hFFFF_FFFF, 1, rft_pkg::KIND_NONE, 0, 7'd0, 7'd4)};
    dir_tab = {dir_tab, row(rft_pkg::OP_PACKET, '1, 32'd7, 32'h1, 16'h1, 32'hFFFF_FFFF,
                            0, rft_pkg::KIND_RECIP, 0, 7'd0, 7'd0)};
    // Age 30 stays, age 31 across the wrap goes.
    dir_tab = {dir_tab, row(rft_pkg::OP_REAP, '1, '1, '1, '1, 32'd30,
                            1, rft_pkg::KIND_REAP, 0, 7'd2, 7'd3)};
    dir_tab = {dir_tab, row(rft_pkg::OP_REAP, 64'h0, 32'h0, 32'h0, 16'h0, 32'd31,
                            1, rft_pkg::KIND_REAP, 0, 7'd3, 7'd0)};
    foreach (dir_tab[i]) send_item(dir_tab[i]);

    // Random phases under max, zero, random and reset TTL values; the first one holds the output.
    ttl_set[0] = 32'hFFFF_FFFF; ttl_set[1] = 32'd0;
    ttl_set[2] = $urandom_range(5, 60); ttl_set[3] = 32'd30;
    now_cnt = 32'hFFFF_FF00 + $urandom_range(0, 255);  // crosses the wrap early
    for (int ph = 0; ph < 4; ph++) begin
      set_ttl(ttl_set[ph]);
      foreach (rooms[i]) rooms[i] = {$urandom, $urandom};
      rooms[0] = '0;
      if (ph == 2) rooms[1] = '1;
      foreach (peers[i]) peers[i] = $urandom;
      quiet_rx = (ph == 3);
      quiet_tx = (ph == 3);
      if (ph == 0) hold_req = 1'b1;
      for (int k = 0; k < 80; k++) begin
        now_cnt += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 3);
        pick = $urandom_range(0, 99);
        it.typed = 1'b0;
        it.res = '0;
        it.op = (pick < 8) ? rft_pkg::OP_REAP : rft_pkg::OP_PACKET;
        // Concentrate traffic on a few rooms so rooms and the table fill up.
        it.room = (pick >= 90) ? {$urandom, $urandom} : rooms[$urandom_range(0, 4)];
        it.peer = (pick >= 95) ? $urandom : peers[$urandom_range(0, 23)];
        it.ip = $urandom; it.port = 16'($urandom); it.now = now_cnt;
        send_item(it);
      end
    end

    wait (fanout_q.size() == 0);
    repeat (DRAIN) @(posedge clk_i);
    $display("Sent %0d transactions, checked %0d results (%0d refused, %0d capped).",
             items_sent, results_seen, refused_seen, capped_seen);
    $display("TTL settings covered: max, zero, random, reset value.");
    if (fail_cnt == 0 && fanout_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+src
src/rft_pkg.sv
src/room_fanout_table_with_aging.sv
src/rft_checker.sv
bench/tb.sv
